// ===== rtl/core/pots_pkg.sv =====
`default_nettype none

package pots_pkg;

   // Number of feature inputs. Each feature is a port of its own on the top level,
   // so this is fixed here.
   localparam int FEATURES  = 4;
   localparam int NUM_CELLS = FEATURES + 1;

   localparam int FEAT_W   = 16;
   localparam int WEIGHT_W = 24;
   localparam int IDX_W    = 3;
   localparam int COUNT_W  = 16;
   localparam int PROD_W   = FEAT_W + WEIGHT_W;
   localparam int SUM_W    = PROD_W + $clog2(NUM_CELLS);

   localparam logic signed [FEAT_W-1:0]   BIAS_RESET = 16'sd4096;
   localparam logic signed [WEIGHT_W:0]   W_MAX      = 25'sd8388607;
   localparam logic signed [WEIGHT_W:0]   W_MIN      = -25'sd8388608;
   localparam logic [COUNT_W-1:0]         COUNT_MAX  = '1;

   localparam logic KIND_TRAIN = 1'b0;
   localparam logic KIND_LOAD  = 1'b1;

   // Per-cycle control that the top level broadcasts to every cell.
   typedef struct packed {
      logic                       capture;
      logic                       update;
      logic                       up;
      logic                       load;
      logic signed [WEIGHT_W-1:0] wval;
   } ctl_type;

   // Adds or subtracts a Q4.12 value from a Q12.12 weight and saturates.
   function automatic logic signed [WEIGHT_W-1:0] sat_step(
      input logic signed [WEIGHT_W-1:0] w,
      input logic signed [FEAT_W-1:0]   x,
      input logic                       up
   );
      logic signed [WEIGHT_W:0] s;
      logic signed [WEIGHT_W:0] we;
      logic signed [WEIGHT_W:0] xe;
      we = (WEIGHT_W+1)'(w);
      xe = (WEIGHT_W+1)'(x);
      s  = up ? (we + xe) : (we - xe);
      if (s > W_MAX) begin
         sat_step = W_MAX[WEIGHT_W-1:0];
      end else if (s < W_MIN) begin
         sat_step = W_MIN[WEIGHT_W-1:0];
      end else begin
         sat_step = s[WEIGHT_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/perceptron_online_train_step.sv =====
// An accepted item waits in stage one until the output register is free, then shows
// its result there. No new item is accepted while stage one holds one: the next item's
// products need the weights that the current item's update writes on leaving stage one.
// Reset (synchronous, active high) clears all weights and the mistake count to zero and
// sets the bias input to 1.0 (Q4.12).
`default_nettype none

module perceptron_online_train_step
   import pots_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      csr_write_enable,
   input  wire logic signed [FEAT_W-1:0]  csr_write_data,

   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_kind,
   input  wire logic signed [FEAT_W-1:0]  req_feature_0,
   input  wire logic signed [FEAT_W-1:0]  req_feature_1,
   input  wire logic signed [FEAT_W-1:0]  req_feature_2,
   input  wire logic signed [FEAT_W-1:0]  req_feature_3,
   input  wire logic                      req_label,
   input  wire logic                      req_last_in_epoch,
   input  wire logic [IDX_W-1:0]          req_weight_index,
   input  wire logic signed [WEIGHT_W-1:0] req_weight_value,

   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_prediction,
   output logic                           rsp_mistake,
   output logic                           rsp_epoch_done,
   output logic [COUNT_W-1:0]             rsp_epoch_errors
);

   // The datapath is a row of cells, one per weight, with the bias weight in the last
   // cell. When an item is accepted, every cell multiplies its input by its weight and
   // keeps the product. While the item is in stage one, the partial sum ripples from cell
   // to cell, the sign of the final sum gives the prediction, and on a mistake every cell
   // updates its own weight as the item leaves; a load item writes one cell's weight.

   logic signed [FEAT_W-1:0] bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= BIAS_RESET;
      end else if (csr_write_enable) begin
         bias_ff <= csr_write_data;
      end
   end

   // Stage one holds the item while the cells hold its products.
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_kind_ff;
   logic                       s1_label_ff;
   logic                       s1_last_ff;
   logic [IDX_W-1:0]           s1_widx_ff;
   logic signed [WEIGHT_W-1:0] s1_wval_ff;

   logic accept;
   logic advance;
   logic out_free;

   assign out_free  = !rsp_valid || rsp_ready;
   assign req_ready = !s1_valid_ff;
   assign accept    = req_valid && req_ready;
   assign advance   = s1_valid_ff && out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_kind;
         s1_label_ff <= req_label;
         s1_last_ff  <= req_last_in_epoch;
         s1_widx_ff  <= req_weight_index;
         s1_wval_ff  <= req_weight_value;
      end
   end

   // Cell inputs: the features, then the bias input for the bias cell.
   logic signed [FEAT_W-1:0] cell_x [NUM_CELLS];
   logic signed [SUM_W-1:0]  chain  [NUM_CELLS+1];
   logic                     load_sel [NUM_CELLS];
   ctl_type                  ctl;

   assign cell_x[0]         = req_feature_0;
   assign cell_x[1]         = req_feature_1;
   assign cell_x[2]         = req_feature_2;
   assign cell_x[3]         = req_feature_3;
   assign cell_x[FEATURES]  = bias_ff;
   assign chain[0]          = '0;

   logic is_train;
   logic pred;
   logic miss;

   assign is_train = advance && (s1_kind_ff == KIND_TRAIN);
   assign pred     = !chain[NUM_CELLS][SUM_W-1];
   assign miss     = pred != s1_label_ff;

   always_comb begin
      ctl.capture = accept;
      ctl.update  = is_train && miss;
      ctl.up      = s1_label_ff;
      ctl.load    = advance && (s1_kind_ff == KIND_LOAD);
      ctl.wval    = s1_wval_ff;
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      assign load_sel[i] = s1_widx_ff == IDX_W'(i);

      pots_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .load_sel (load_sel[i]),
         .x        (cell_x[i]),
         .sum_in   (chain[i]),
         .sum_out  (chain[i+1])
      );
   end

   // Mistake counter. It saturates, and the item that closes an epoch reports the
   // count including its own mistake and clears it.
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_bumped;

   assign count_bumped = (miss && (count_ff != COUNT_MAX)) ? (count_ff + 1'b1) : count_ff;

   always_comb begin
      count_in = count_ff;
      if (is_train) begin
         count_in = s1_last_ff ? '0 : count_bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Output register. A load item reports all zeros.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_prediction   <= is_train && pred;
         rsp_mistake      <= is_train && miss;
         rsp_epoch_done   <= is_train && s1_last_ff;
         rsp_epoch_errors <= (is_train && s1_last_ff) ? count_bumped : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pots_cell.sv =====
`default_nettype none

module pots_cell
   import pots_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctl_type                 ctl,
   input  wire logic                    load_sel,
   input  wire logic signed [FEAT_W-1:0] x,
   input  wire logic signed [SUM_W-1:0]  sum_in,
   output logic signed [SUM_W-1:0]       sum_out
);

   logic signed [FEAT_W-1:0]   x_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [WEIGHT_W-1:0] weight_ff;
   logic signed [WEIGHT_W-1:0] weight_in;

   assign prod_in = x * weight_ff;
   assign sum_out = sum_in + SUM_W'(prod_ff);

   always_comb begin
      weight_in = weight_ff;
      if (ctl.update) begin
         weight_in = sat_step(weight_ff, x_ff, ctl.up);
      end else if (ctl.load && load_sel) begin
         weight_in = ctl.wval;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         x_ff    <= x;
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
      end else begin
         weight_ff <= weight_in;
      end
   end

endmodule

`default_nettype wire
